[src/huffman_tree_table_engine_assert.svh]
// Assertion macros shared by the tree table engine modules.
// Expects aclk and aresetn in scope at the point of use.
`ifndef HUFFMAN_TREE_TABLE_ENGINE_ASSERT_SVH
`define HUFFMAN_TREE_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication
`define HTTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HTTE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/htte_pkg.sv]
// Types and constants for the Huffman tree table engine.
// No dependencies; imported by the controller, datapath and top level.
package htte_pkg;

    localparam int IDX_W      = 9;
    localparam int NODE_LIMIT = 512;
    localparam int SYM_IN_W   = 8;
    localparam int BYTE_W     = 8;
    localparam int BITS_W     = 4;
    localparam int CHUNK_W    = 64;
    localparam int CODE_W     = 512;
    localparam int CHUNK_CNT_W = 4;
    localparam int LEN_MAX    = 511;

    typedef enum logic [1:0] {
        REQ_LEAF   = 2'd0,
        REQ_NODE   = 2'd1,
        REQ_CODE   = 2'd2,
        REQ_DECODE = 2'd3
    } req_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_e;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [SYM_IN_W-1:0] symbol;
        logic [IDX_W-1:0]    left_index;
        logic [IDX_W-1:0]    right_index;
        logic [IDX_W-1:0]    start_node;
        logic [BYTE_W-1:0]   code_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   node_out;
        logic [BITS_W-1:0]  bits_used;
        logic [IDX_W-1:0]   code_len;
        logic [CHUNK_W-1:0] code_chunk;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic append;
        logic link_left;
        logic link_right;
        logic walk_init;
        logic mem_rd;
        logic step;
        logic chunks_init;
        logic out_load;
    } htte_cmd_t;

    typedef struct packed {
        status_e err;
        req_e    req;
        logic    climb_go;
        logic    desc_go;
        logic    last;
    } htte_sts_t;

endpackage

[src/htte_datapath.sv]
// Datapath of the tree table engine: node memories, walk registers, result register.
// Depends on htte_pkg; driven by htte_ctrl through htte_cmd_t.
module htte_datapath import htte_pkg::*; #(
    parameter int CAP   = 512,
    parameter int SYM_W = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_word_t  s_word,
    input  htte_cmd_t cmd,
    output htte_sts_t sts,
    output out_word_t m_word
);

    localparam int AW = $clog2(CAP);
    localparam int CW = $clog2(CAP + 1);

    typedef struct packed {
        logic             leaf;
        logic [AW-1:0]    left;
        logic [AW-1:0]    right;
        logic [SYM_W-1:0] sym;
    } shape_t;

    typedef struct packed {
        logic          is_left;
        logic          has_parent;
        logic [AW-1:0] parent;
    } link_t;

    shape_t shape_mem [CAP];
    link_t  link_mem  [CAP];

    in_word_t               in_reg;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          p_reg, p_next;
    logic [IDX_W-1:0]       len_reg, len_next;
    logic [BITS_W-1:0]      left_reg, left_next;
    logic [BYTE_W-1:0]      byte_reg, byte_next;
    logic [CODE_W-1:0]      code_reg, code_next;
    logic [CHUNK_CNT_W-1:0] chunk_reg, chunk_next;
    shape_t                 shape_rd_reg;
    link_t                  link_rd_reg;
    out_word_t              out_reg;
    status_e                err_reg, err_next;

    req_e      req;
    req_e      req_in;
    out_word_t res;
    logic      full, start_bad, li_bad, ri_bad;
    logic      shape_we, link_we;
    logic [AW-1:0] shape_wa, link_wa;
    shape_t    shape_wd;
    link_t     link_wd;
    logic [IDX_W:0] len_round;

    assign req       = req_e'(in_reg.req_type);
    assign req_in    = req_e'(s_word.req_type);
    assign full      = count_reg >= CW'(CAP);
    assign start_bad = {1'b0, s_word.start_node} >= (IDX_W + 1)'(count_reg);
    assign li_bad    = {1'b0, s_word.left_index} >= (IDX_W + 1)'(count_reg);
    assign ri_bad    = {1'b0, s_word.right_index} >= (IDX_W + 1)'(count_reg);
    assign len_round = (IDX_W + 1)'(len_reg) + (IDX_W + 1)'(CHUNK_W - 1);

    always_comb begin
        err_next = ST_OK;
        priority if ((req_in == REQ_LEAF || req_in == REQ_NODE) && full) begin
            err_next = ST_FULL;
        end else if (req_in == REQ_NODE && (li_bad || ri_bad)) begin
            err_next = ST_RANGE;
        end else if ((req_in == REQ_CODE || req_in == REQ_DECODE) && start_bad) begin
            err_next = ST_RANGE;
        end else begin
            err_next = ST_OK;
        end
    end

    always_comb begin
        res      = '0;
        res.last = 1'b1;
        if (err_reg != ST_OK) begin
            res.status = err_reg;
        end else begin
            unique case (req)
                REQ_LEAF, REQ_NODE: begin
                    res.node_out = IDX_W'(p_reg);
                end
                REQ_CODE: begin
                    res.code_len   = len_reg;
                    res.code_chunk = code_reg[CODE_W-1 -: CHUNK_W];
                    res.last       = chunk_reg == CHUNK_CNT_W'(1);
                end
                REQ_DECODE: begin
                    res.node_out  = IDX_W'(p_reg);
                    res.bits_used = BITS_W'(BYTE_W) - left_reg;
                end
            endcase
        end
    end

    always_comb begin
        sts.err      = err_reg;
        sts.req      = req;
        sts.climb_go = link_rd_reg.has_parent && (len_reg != IDX_W'(LEN_MAX));
        sts.desc_go  = !shape_rd_reg.leaf && (left_reg != '0);
        sts.last     = res.last;
    end

    always_comb begin
        shape_we      = cmd.append;
        shape_wa      = count_reg[AW-1:0];
        shape_wd.leaf = req == REQ_LEAF;
        shape_wd.left  = (req == REQ_NODE) ? in_reg.left_index[AW-1:0] : '0;
        shape_wd.right = (req == REQ_NODE) ? in_reg.right_index[AW-1:0] : '0;
        shape_wd.sym   = (req == REQ_LEAF) ? SYM_W'(in_reg.symbol) : '0;

        link_we = cmd.append || cmd.link_left || cmd.link_right;
        link_wa = count_reg[AW-1:0];
        link_wd = '0;
        if (cmd.link_left) begin
            link_wa = in_reg.left_index[AW-1:0];
            link_wd = '{is_left: 1'b1, has_parent: 1'b1, parent: p_reg};
        end else if (cmd.link_right) begin
            link_wa = in_reg.right_index[AW-1:0];
            link_wd = '{is_left: 1'b0, has_parent: 1'b1, parent: p_reg};
        end
    end

    always_comb begin
        count_next = count_reg;
        p_next     = p_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        byte_next  = byte_reg;
        code_next  = code_reg;
        chunk_next = chunk_reg;
        if (cmd.append) begin
            count_next = count_reg + CW'(1);
            p_next     = count_reg[AW-1:0];
        end
        if (cmd.walk_init) begin
            p_next    = in_reg.start_node[AW-1:0];
            len_next  = '0;
            left_next = BITS_W'(BYTE_W);
            byte_next = in_reg.code_byte;
            code_next = '0;
        end
        if (cmd.step) begin
            if (req == REQ_CODE) begin
                code_next = {link_rd_reg.is_left, code_reg[CODE_W-1:1]};
                len_next  = len_reg + IDX_W'(1);
                p_next    = link_rd_reg.parent;
            end else begin
                p_next    = byte_reg[BYTE_W-1] ? shape_rd_reg.left : shape_rd_reg.right;
                byte_next = {byte_reg[BYTE_W-2:0], 1'b0};
                left_next = left_reg - BITS_W'(1);
            end
        end
        if (cmd.chunks_init) begin
            chunk_next = (len_reg == '0) ? CHUNK_CNT_W'(1)
                                         : len_round[IDX_W -: CHUNK_CNT_W];
        end
        if (cmd.out_load) begin
            code_next  = code_reg << CHUNK_W;
            chunk_next = chunk_reg - CHUNK_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg  <= s_word;
            err_reg <= err_next;
        end
        if (cmd.out_load) begin
            out_reg <= res;
        end
        p_reg     <= p_next;
        len_reg   <= len_next;
        left_reg  <= left_next;
        byte_reg  <= byte_next;
        code_reg  <= code_next;
        chunk_reg <= chunk_next;
    end

    always_ff @(posedge aclk) begin
        if (shape_we) begin
            shape_mem[shape_wa] <= shape_wd;
        end
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (cmd.mem_rd) begin
            shape_rd_reg <= shape_mem[p_reg];
            link_rd_reg  <= link_mem[p_reg];
        end
    end

    assign m_word = out_reg;

    `include "huffman_tree_table_engine_assert.svh"

    `HTTE_ASSERT_IMP(a_append_room, cmd.append, count_reg < CW'(CAP), "append on full table")
    `HTTE_ASSERT_IMP(a_decode_room, cmd.step && req == REQ_DECODE, left_reg != '0,
        "decode step with no bits left")
    `HTTE_ASSERT_IMP(a_chunk_left, cmd.out_load && req == REQ_CODE && err_reg == ST_OK,
        chunk_reg != '0, "code chunk emitted past the end")

endmodule

[src/htte_ctrl.sv]
// Controller of the tree table engine: request sequencing and result handshake.
// Depends on htte_pkg; commands htte_datapath through htte_cmd_t.
module htte_ctrl import htte_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  htte_sts_t sts,
    output htte_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LINK_L,
        S_LINK_R,
        S_RD,
        S_STEP,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.err != ST_OK) begin
                    state_next = S_OUT;
                end else begin
                    unique case (sts.req)
                        REQ_LEAF: begin
                            cmd.append = 1'b1;
                            state_next = S_OUT;
                        end
                        REQ_NODE: begin
                            cmd.append = 1'b1;
                            state_next = S_LINK_L;
                        end
                        REQ_CODE, REQ_DECODE: begin
                            cmd.walk_init = 1'b1;
                            state_next    = S_RD;
                        end
                    endcase
                end
            end
            S_LINK_L: begin
                cmd.link_left = 1'b1;
                state_next    = S_LINK_R;
            end
            S_LINK_R: begin
                cmd.link_right = 1'b1;
                state_next     = S_OUT;
            end
            S_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_STEP;
            end
            S_STEP: begin
                if (sts.req == REQ_CODE) begin
                    if (sts.climb_go) begin
                        cmd.step   = 1'b1;
                        state_next = S_RD;
                    end else begin
                        cmd.chunks_init = 1'b1;
                        state_next      = S_OUT;
                    end
                end else if (sts.desc_go) begin
                    cmd.step   = 1'b1;
                    state_next = S_RD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

    `include "huffman_tree_table_engine_assert.svh"

    `HTTE_ASSERT_IMP(a_no_overwrite, cmd.out_load, !m_valid_reg || m_ready,
        "result register overwritten while pending")
    `HTTE_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
        "second word taken while a request is in flight")
    `HTTE_ASSERT_IMP(a_step_has_work, cmd.step,
        (sts.req == REQ_CODE && sts.climb_go) || (sts.req == REQ_DECODE && sts.desc_go),
        "walk step without a node to move to")

endmodule

[src/huffman_tree_table_engine.sv]
// Channel  | Dir | Handshake          | Word
// s_       | in  | s_valid / s_ready  | in_word_t  (request)
// m_       | out | m_valid / m_ready  | out_word_t (result, last marks end of request)
// Add leaf: load, check and append, then result load; add internal node: two link writes before the result load.
// Decode: one table read and one step per node visited, at most one step per code bit.
// Get code: one table read and one step per level climbed, then one result word per 64-bit chunk.
// The node table has one read port with registered data, so each node takes a read state and a step state.
// Reset is synchronous, active low, and empties the table at once; a stalled m_ word
// holds and the engine waits in its output state; a new request is taken while the
// final word of the previous one waits.
module huffman_tree_table_engine import htte_pkg::*; #(
    parameter int MAX_NODES   = 512,
    parameter int SYMBOL_BITS = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    localparam int CAP = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;

    htte_cmd_t cmd;
    htte_sts_t sts;

    htte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    htte_datapath #(
        .CAP   (CAP),
        .SYM_W (SYMBOL_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .cmd     (cmd),
        .sts     (sts),
        .m_word  (m_word)
    );

endmodule

[sim/huffman_tree_table_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the Huffman tree table engine: mirrors the node table, predicts
// the result words of every accepted request and compares them as they leave.
// Depends on htte_pkg for the word types, request and status codes.
module huffman_tree_table_checker import htte_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_word,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_word,
    output int        fail_count,
    output int        words_due,
    output int        req_seen,
    output int        words_seen,
    output int        longest_code
);

    localparam int TABLE_CAP = 512;

    typedef struct packed {
        bit                leaf;
        bit                is_left;
        bit                has_parent;
        bit [IDX_W-1:0]    parent;
        bit [IDX_W-1:0]    left;
        bit [IDX_W-1:0]    right;
        bit [SYM_IN_W-1:0] sym;
    } tree_node_t;

    tree_node_t tree[TABLE_CAP];
    int         tree_size;
    out_word_t  due_q[$];
    out_word_t  want;
    int         fails;
    int         reqs;
    int         words;
    int         max_len;

    function automatic void push_result(status_e st, logic [IDX_W-1:0] node,
                                        logic [BITS_W-1:0] used, logic [IDX_W-1:0] clen,
                                        logic [CHUNK_W-1:0] chunk, logic fin);
        out_word_t r;
        r.status     = st;
        r.node_out   = node;
        r.bits_used  = used;
        r.code_len   = clen;
        r.code_chunk = chunk;
        r.last       = fin;
        due_q.insert(due_q.size(), r);
    endfunction

    function automatic void model_request(in_word_t w);
        int unsigned       pos;
        int unsigned       p;
        int unsigned       len;
        int unsigned       chunks;
        int unsigned       steps;
        int unsigned       c;
        int unsigned       j;
        logic [BYTE_W-1:0] bits;
        bit [CODE_W-1:0]   path;
        bit [CHUNK_W-1:0]  chunk;
        unique case (req_e'(w.req_type))
            REQ_LEAF, REQ_NODE: begin
                if (tree_size >= TABLE_CAP) begin
                    push_result(ST_FULL, '0, '0, '0, '0, 1'b1);
                end else if (w.req_type == REQ_NODE &&
                             (w.left_index >= tree_size || w.right_index >= tree_size)) begin
                    push_result(ST_RANGE, '0, '0, '0, '0, 1'b1);
                end else begin
                    pos = tree_size;
                    tree[pos] = '0;
                    if (w.req_type == REQ_LEAF) begin
                        tree[pos].leaf = 1'b1;
                        tree[pos].sym  = w.symbol;
                    end else begin
                        tree[pos].left  = w.left_index;
                        tree[pos].right = w.right_index;
                        tree[w.left_index].is_left     = 1'b1;
                        tree[w.left_index].has_parent  = 1'b1;
                        tree[w.left_index].parent      = pos[IDX_W-1:0];
                        tree[w.right_index].is_left    = 1'b0;
                        tree[w.right_index].has_parent = 1'b1;
                        tree[w.right_index].parent     = pos[IDX_W-1:0];
                    end
                    tree_size++;
                    push_result(ST_OK, pos[IDX_W-1:0], '0, '0, '0, 1'b1);
                end
            end
            default: begin
                if (w.start_node >= tree_size) begin
                    push_result(ST_RANGE, '0, '0, '0, '0, 1'b1);
                end else if (w.req_type == REQ_CODE) begin
                    p    = 32'(w.start_node);
                    len  = 0;
                    path = '0;
                    while (tree[p].has_parent && len < LEN_MAX) begin
                        path[len] = tree[p].is_left;
                        len++;
                        p = 32'(tree[p].parent);
                    end
                    chunks = (len + CHUNK_W - 1) / CHUNK_W;
                    if (chunks == 0) chunks = 1;
                    for (c = 0; c < chunks; c++) begin
                        chunk = '0;
                        for (j = 0; j < CHUNK_W; j++) begin
                            if (c * CHUNK_W + j < len)
                                chunk[CHUNK_W-1-j] = path[len-1-(c*CHUNK_W+j)];
                        end
                        push_result(ST_OK, '0, '0, len[IDX_W-1:0], chunk, c == chunks - 1);
                    end
                    if (len > max_len) max_len = len;
                end else begin
                    p     = 32'(w.start_node);
                    bits  = w.code_byte;
                    steps = 0;
                    while (steps < BYTE_W && !tree[p].leaf) begin
                        p = bits[BYTE_W-1] ? 32'(tree[p].left) : 32'(tree[p].right);
                        bits = bits << 1;
                        steps++;
                    end
                    push_result(ST_OK, p[IDX_W-1:0], steps[BITS_W-1:0], '0, '0, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [CHUNK_W-1:0] exp_v,
                                        logic [CHUNK_W-1:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            tree_size = 0;
            due_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                words++;
                if (due_q.size() == 0) begin
                    $error("result word with nothing outstanding: status %0d node %0d",
                           m_word.status, m_word.node_out);
                    fails++;
                end else begin
                    want = due_q.pop_front();
                    check_field("status", CHUNK_W'(want.status), CHUNK_W'(m_word.status));
                    check_field("node_out", CHUNK_W'(want.node_out),
                                CHUNK_W'(m_word.node_out));
                    check_field("bits_used", CHUNK_W'(want.bits_used),
                                CHUNK_W'(m_word.bits_used));
                    check_field("code_len", CHUNK_W'(want.code_len),
                                CHUNK_W'(m_word.code_len));
                    check_field("code_chunk", want.code_chunk, m_word.code_chunk);
                    check_field("last", CHUNK_W'(want.last), CHUNK_W'(m_word.last));
                end
            end
            if (s_valid && s_ready) begin
                reqs++;
                model_request(s_word);
            end
        end
        fail_count   <= fails;
        words_due    <= due_q.size();
        req_seen     <= reqs;
        words_seen   <= words;
        longest_code <= max_len;
    end

endmodule

[sim/tb_huffman_tree_table_engine.sv]
`timescale 1ns / 1ps
// Testbench top for the Huffman tree table engine: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Uses htte_pkg and the checker module.
module tb_huffman_tree_table_engine;
    import htte_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int TABLE_CAP  = 512;
    localparam int BUILD_CAP  = 40;
    localparam int CHAIN_LEN  = 66;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    int fail_count;
    int words_due;
    int req_seen;
    int words_seen;
    int longest_code;

    int nodes_made  = 0;
    int idle_cycles = 0;
    int m_hold      = 0;
    int m_roll;
    bit m_calm      = 1'b0;
    bit s_calm      = 1'b0;

    always #5 aclk = ~aclk;

    huffman_tree_table_engine dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    huffman_tree_table_checker scoreboard (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_word       (s_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word       (m_word),
        .fail_count   (fail_count),
        .words_due    (words_due),
        .req_seen     (req_seen),
        .words_seen   (words_seen),
        .longest_code (longest_code)
    );

    always @(posedge aclk) begin
        if ($urandom_range(0, 63) == 0) m_calm = !m_calm;
        if (m_hold > 0) begin
            m_hold--;
        end else if (!m_calm) begin
            m_roll = $urandom_range(0, 99);
            if (m_roll < 4) m_hold = $urandom_range(8, 40);
            else if (m_roll < 25) m_hold = $urandom_range(1, 3);
        end
        m_ready <= (m_hold == 0);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic in_word_t rand_word(req_e req);
        logic [63:0] r;
        in_word_t    w;
        r = {$urandom, $urandom};
        w = r[$bits(in_word_t)-1:0];
        w.req_type = req;
        return w;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (s_calm || roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_recent();
        int span;
        span = (nodes_made < 8) ? nodes_made : 8;
        return nodes_made - 1 - $urandom_range(0, span - 1);
    endfunction

    task automatic send_req(input in_word_t w);
        int gap;
        s_word  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if ($urandom_range(0, 19) == 0) s_calm = !s_calm;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic add_leaf(input logic [SYM_IN_W-1:0] sym);
        in_word_t w;
        w = rand_word(REQ_LEAF);
        w.symbol = sym;
        send_req(w);
        if (nodes_made < TABLE_CAP) nodes_made++;
    endtask

    task automatic add_inner(input int l, input int r);
        in_word_t w;
        w = rand_word(REQ_NODE);
        w.left_index  = l[IDX_W-1:0];
        w.right_index = r[IDX_W-1:0];
        send_req(w);
        if (nodes_made < TABLE_CAP && l < nodes_made && r < nodes_made) nodes_made++;
    endtask

    task automatic ask_code(input int start);
        in_word_t w;
        w = rand_word(REQ_CODE);
        w.start_node = start[IDX_W-1:0];
        send_req(w);
    endtask

    task automatic ask_decode(input int start, input logic [BYTE_W-1:0] code_bits);
        in_word_t w;
        w = rand_word(REQ_DECODE);
        w.start_node = start[IDX_W-1:0];
        w.code_byte  = code_bits;
        send_req(w);
    endtask

    initial begin
        int roll;
        int deep_leaf;
        int top_node;
        int other;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table, then a small tree with reparenting and a shared child
        ask_code(0);
        ask_decode(0, 8'hA5);
        add_inner(0, 0);
        add_leaf(8'h00);
        add_leaf(8'hFF);
        add_inner(0, 1);
        ask_code(0);
        ask_code(1);
        ask_code(2);
        ask_decode(2, 8'h80);
        ask_decode(2, 8'h7F);
        ask_decode(0, 8'hFF);
        add_inner(2, 2);
        add_inner(511, 0);
        add_inner(0, 511);
        ask_code(511);
        ask_decode(511, 8'h00);
        add_inner(0, 1);
        ask_code(0);
        ask_code(2);
        ask_decode(3, 8'hFF);
        add_inner(3, 3);
        add_inner(5, 4);
        ask_decode(6, 8'h80);

        repeat (25) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                case ($urandom_range(0, 3))
                    0: if (nodes_made < BUILD_CAP) add_leaf(8'($urandom_range(0, 255)));
                       else ask_code($urandom_range(0, 511));
                    1: if (nodes_made < BUILD_CAP)
                           add_inner($urandom_range(0, 511), $urandom_range(0, 511));
                       else ask_decode($urandom_range(0, 511), 8'($urandom_range(0, 255)));
                    2: ask_code($urandom_range(0, 511));
                    default: ask_decode($urandom_range(0, 511), 8'($urandom_range(0, 255)));
                endcase
            end else if (roll < 30 && nodes_made < BUILD_CAP) begin
                add_leaf(8'($urandom_range(0, 255)));
            end else if (roll < 50 && nodes_made < BUILD_CAP) begin
                add_inner(pick_recent(), pick_recent());
            end else if (roll < 75) begin
                ask_code($urandom_range(0, nodes_made - 1));
            end else begin
                ask_decode($urandom_range(0, nodes_made - 1), 8'($urandom_range(0, 255)));
            end
        end

        // grow one deep chain so that its code spans two chunks
        add_leaf(8'($urandom_range(0, 255)));
        deep_leaf = nodes_made - 1;
        top_node  = deep_leaf;
        repeat (CHAIN_LEN) begin
            other = $urandom_range(0, deep_leaf - 1);
            if ($urandom_range(0, 1)) add_inner(top_node, other);
            else add_inner(other, top_node);
            top_node = nodes_made - 1;
        end

        add_leaf(8'h5A);
        add_inner(0, 1);
        add_inner(511, 511);
        ask_code(deep_leaf);
        ask_decode(top_node, 8'hFF);
        ask_decode(top_node, 8'h00);
        repeat (10) begin
            if ($urandom_range(0, 1)) ask_code($urandom_range(0, 511));
            else ask_decode($urandom_range(0, 511), 8'($urandom_range(0, 255)));
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (words_due != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Covered %0d requests and %0d result words.", req_seen, words_seen);
        $display("Table reached %0d nodes; longest code %0d bits.", nodes_made, longest_code);
        if (fail_count == 0 && words_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
